@@ sv/sfr_pkg.sv @@
// Shared types and constants for the streaming find-and-replace block.
// No dependencies; imported by sfr_cell and stream_find_and_replace.
package sfr_pkg;

  // Default sizes of the held-byte chain and the replacement string
  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;

  // Configuration register geometry
  localparam int CFG_DATA_W = 64;
  localparam int CFG_LEN_W  = 4;
  localparam int REG_BYTES  = 8;
  localparam int MATCH_W    = 16;

  typedef logic [7:0] byte_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PAT_LEN   = 2'd0,
    CFG_PAT_BYTES = 2'd1,
    CFG_REP_LEN   = 2'd2,
    CFG_REP_BYTES = 2'd3
  } cfg_idx_t;

endpackage

@@ sv/stream_find_and_replace.sv @@
// Streaming find-and-replace: top level with configuration registers,
// the chain of sfr_cell held-byte cells and the scan sequencer. Uses sfr_pkg.
//
// Usage:
//   Input transactions (in_valid/in_stall) carry one text byte and a flag
//   marking the last byte of the text. Output transactions (out_valid/
//   out_stall) carry one text byte each, or a bare end marker, with flags
//   for the last result of an input and of the whole text, plus the
//   saturating count of replacements made so far.
//   Configuration is a write-only port (cfg_we, cfg_index, cfg_data); write
//   it only while no transaction is in flight. Writing the pattern length
//   or pattern bytes discards any held partial match.
// Sequencing:
//   An input is taken in S_IDLE; the sequencer then moves to S_SCAN,
//   which emits held bytes from the head of the cell chain, or, when they
//   complete a match, to S_REPL, which emits the replacement bytes (none
//   for a match deleted by an empty replacement mid-text). An item that
//   only extends a partial match produces no result. The sequencer emits
//   one byte per cycle from the head of the cell chain or the replacement
//   when the output is not stalled, and registers each result it emits.
// Reset and stall:
//   rst_n (synchronous) empties the chain, zeroes the match count, loads
//   pattern length 1 and zeroes other config and sequencer registers, not
//   output data. A stalled result holds in the output register and no new
//   result is made; in_stall is high whenever an item is being worked on.
module stream_find_and_replace import sfr_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char,
  input  logic                  in_stream_end,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  out_has_char,
  output logic                  out_run_last,
  output logic                  out_text_done,
  output logic [MATCH_W-1:0]    out_match_total,
  // configuration port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
  localparam int RCNT_W = $clog2(REPLACE_MAX + 1);
  localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REPL} state_t;

  // Configuration registers
  logic [CFG_LEN_W-1:0]  cfg_plen_r;
  logic [CFG_DATA_W-1:0] cfg_pbytes_r;
  logic [CFG_LEN_W-1:0]  cfg_rlen_r;
  logic [CFG_DATA_W-1:0] cfg_rbytes_r;
  logic                  pat_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_plen_r   <= CFG_LEN_W'(1);
      cfg_pbytes_r <= '0;
      cfg_rlen_r   <= '0;
      cfg_rbytes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_LEN:   cfg_plen_r   <= cfg_data[CFG_LEN_W-1:0];
        CFG_PAT_BYTES: cfg_pbytes_r <= cfg_data;
        CFG_REP_LEN:   cfg_rlen_r   <= cfg_data[CFG_LEN_W-1:0];
        CFG_REP_BYTES: cfg_rbytes_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Pattern writes discard held bytes
  assign pat_wr = cfg_we && ((cfg_idx_t'(cfg_index) == CFG_PAT_LEN) ||
                             (cfg_idx_t'(cfg_index) == CFG_PAT_BYTES));

  // Effective lengths, clamped to the chain and replacement sizes
  logic [CNT_W-1:0]  plen_eff;
  logic [RCNT_W-1:0] rlen_eff;

  always_comb begin
    if (cfg_plen_r == '0) begin
      plen_eff = CNT_W'(1);
    end else if (int'(cfg_plen_r) > PATTERN_MAX) begin
      plen_eff = CNT_W'(PATTERN_MAX);
    end else begin
      plen_eff = CNT_W'(cfg_plen_r);
    end
    if (int'(cfg_rlen_r) > REPLACE_MAX) begin
      rlen_eff = RCNT_W'(REPLACE_MAX);
    end else begin
      rlen_eff = RCNT_W'(cfg_rlen_r);
    end
  end

  // Replacement bytes by position; positions past the register read zero
  byte_t rep_arr [2**RIDX_W];

  for (genvar r = 0; r < 2**RIDX_W; r++) begin : g_rep
    if (r < REG_BYTES) begin : g_in
      assign rep_arr[r] = cfg_rbytes_r[8*r +: 8];
    end else begin : g_zero
      assign rep_arr[r] = '0;
    end
  end

  // Sequencer registers
  state_t             state_r,     state_nxt;
  logic [CNT_W-1:0]   count_r,     count_nxt;
  logic               end_r,       end_nxt;
  logic [RCNT_W-1:0]  rep_cnt_r,   rep_cnt_nxt;
  logic [MATCH_W-1:0] match_cnt_r, match_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  byte_t              out_char_r,  out_char_nxt;
  logic               out_has_r,   out_has_nxt;
  logic               out_last_r,  out_last_nxt;
  logic               out_done_r,  out_done_nxt;
  logic [MATCH_W-1:0] out_total_r, out_total_nxt;

  // Chain of held-byte cells
  logic  load_en;
  logic  shift_en;
  byte_t cell_byte [PATTERN_MAX];
  logic  eq_here   [PATTERN_MAX];
  logic  eq_next   [PATTERN_MAX];

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    byte_t pat_b;
    byte_t nbr_b;

    if (i < REG_BYTES) begin : g_pat
      assign pat_b = cfg_pbytes_r[8*i +: 8];
    end else begin : g_pat_zero
      assign pat_b = '0;
    end

    if (i < PATTERN_MAX - 1) begin : g_nbr
      assign nbr_b = cell_byte[i+1];
    end else begin : g_nbr_end
      assign nbr_b = '0;
    end

    sfr_cell u_cell (
      .clk      (clk),
      .load_en  (load_en && (count_r == CNT_W'(i))),
      .shift_en (shift_en),
      .new_byte (in_char),
      .nbr_byte (nbr_b),
      .pat_byte (pat_b),
      .byte_q   (cell_byte[i]),
      .eq_here  (eq_here[i]),
      .eq_next  (eq_next[i])
    );
  end

  // Prefix match of held bytes, now and after one shift
  logic all_ok;
  logic all_ok_next;
  logic full_match;

  always_comb begin
    all_ok      = 1'b1;
    all_ok_next = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((CNT_W'(i) < count_r) && !eq_here[i]) begin
        all_ok = 1'b0;
      end
      if ((CNT_W'(i + 1) < count_r) && !eq_next[i]) begin
        all_ok_next = 1'b0;
      end
    end
  end

  assign full_match = all_ok && (count_r == plen_eff);

  // Sequencer next state
  logic adv;
  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    end_nxt       = end_r;
    rep_cnt_nxt   = rep_cnt_r;
    match_cnt_nxt = match_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    out_total_nxt = out_total_r;
    load_en       = 1'b0;
    shift_en      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          load_en   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          end_nxt   = in_stream_end;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (full_match) begin
          // whole pattern held: count it and play out the replacement
          if (match_cnt_r != '1) begin
            match_cnt_nxt = match_cnt_r + MATCH_W'(1);
          end
          count_nxt   = '0;
          rep_cnt_nxt = '0;
          state_nxt   = S_REPL;
        end else if (end_r) begin
          // end of text: flush everything held
          if (adv) begin
            shift_en      = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
            out_valid_nxt = 1'b1;
            out_char_nxt  = cell_byte[0];
            out_has_nxt   = 1'b1;
            out_last_nxt  = (count_r == CNT_W'(1));
            out_done_nxt  = (count_r == CNT_W'(1));
            out_total_nxt = match_cnt_r;
            if (count_r == CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (all_ok) begin
          // still a partial match: hold and wait for more
          state_nxt = S_IDLE;
        end else if (adv) begin
          // head byte cannot start a match: emit it and realign
          shift_en      = 1'b1;
          count_nxt     = count_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_char_nxt  = cell_byte[0];
          out_has_nxt   = 1'b1;
          out_last_nxt  = all_ok_next;
          out_done_nxt  = 1'b0;
          out_total_nxt = match_cnt_r;
          if (all_ok_next) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_REPL: begin
        if (rlen_eff == '0) begin
          // match deleted; bare end marker if the text ends here
          if (!end_r) begin
            state_nxt = S_IDLE;
          end else if (adv) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = '0;
            out_has_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
            out_done_nxt  = 1'b1;
            out_total_nxt = match_cnt_r;
            state_nxt     = S_IDLE;
          end
        end else if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rep_arr[rep_cnt_r[RIDX_W-1:0]];
          out_has_nxt   = 1'b1;
          out_last_nxt  = (rep_cnt_r + RCNT_W'(1) == rlen_eff);
          out_done_nxt  = end_r && (rep_cnt_r + RCNT_W'(1) == rlen_eff);
          out_total_nxt = match_cnt_r;
          rep_cnt_nxt   = rep_cnt_r + RCNT_W'(1);
          if (rep_cnt_r + RCNT_W'(1) == rlen_eff) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // pattern change drops the held partial match
    if (pat_wr) begin
      count_nxt = '0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      end_r       <= 1'b0;
      rep_cnt_r   <= '0;
      match_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      end_r       <= end_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      match_cnt_r <= match_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r  <= out_char_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
    out_total_r <= out_total_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_has_char    = out_has_r;
  assign out_run_last    = out_last_r;
  assign out_text_done   = out_done_r;
  assign out_match_total = out_total_r;

endmodule

@@ sv/sfr_cell.sv @@
// One cell of the held-byte chain: stores a byte, compares it and the byte of
// its right-hand neighbour against its pattern byte. Uses sfr_pkg.
module sfr_cell import sfr_pkg::*; (
  input  logic  clk,
  input  logic  load_en,
  input  logic  shift_en,
  input  byte_t new_byte,
  input  byte_t nbr_byte,
  input  byte_t pat_byte,
  output byte_t byte_q,
  output logic  eq_here,
  output logic  eq_next
);

  byte_t byte_r;

  // Append a new byte here, or take the neighbour's byte on a shift
  always_ff @(posedge clk) begin
    if (load_en) begin
      byte_r <= new_byte;
    end else if (shift_en) begin
      byte_r <= nbr_byte;
    end
  end

  // Compare for the current alignment and for the one after a shift
  assign eq_here = (byte_r == pat_byte);
  assign eq_next = (nbr_byte == pat_byte);
  assign byte_q  = byte_r;

endmodule
